@@ hw/rtl/random_pixel_diffuse_macros.svh @@
// Assertion macros for the random pixel diffuse block.
// Included by the RTL files that carry concurrent assertions; needs no other file.
`ifndef RANDOM_PIXEL_DIFFUSE_MACROS_SVH
`define RANDOM_PIXEL_DIFFUSE_MACROS_SVH
`ifndef SYNTH
// Plain property, checked at every rising edge outside reset.
`define RPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication: post must hold in the cycle after pre.
`define RPD_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define RPD_ASSERT(label, clk, rst, prop, msg)
`define RPD_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

@@ hw/rtl/rpd_pkg.sv @@
// Shared types and constants of the random pixel diffuse block.
// Used by every RTL file of the block; depends on nothing.
package rpd_pkg;

  localparam int COORD_W    = 9;
  localparam int GEOM_W     = 9;
  localparam int RANGE_W    = 8;
  localparam int SPAN_W     = 9;
  localparam int ADDR_SUM_W = 2 * COORD_W + 1;
  localparam int CFG_IDX_W  = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_RANGE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED     = 8'd3;

  localparam logic [31:0]        LCG_MUL     = 32'd1103515245;
  localparam logic [31:0]        LCG_INC     = 32'd12345;
  localparam logic [RANGE_W-1:0] RESET_RANGE = 8'd1;
  localparam logic [31:0]        RESET_SEED  = 32'd1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic        last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [GEOM_W-1:0]  frame_width;
    logic [GEOM_W-1:0]  frame_height;
    logic [RANGE_W-1:0] spread_range;
  } cfg_t;

  // One classified command between the front and the back.
  typedef struct packed {
    logic               is_emit;
    logic [31:0]        pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DRAW,
    B_MOD,
    B_ADDR,
    B_OUT
  } back_state_t;

endpackage

@@ hw/rtl/random_pixel_diffuse.sv @@
// Top level of the random pixel diffuse (random jitter) filter.
// Holds the configuration registers and joins front, command queue and back;
// depends on rpd_pkg, rpd_front, rpd_cmd_queue and rpd_back.
//
// Push load beats (opcode 0) to fill the frame store in raster order, then push
// emit beats (opcode 1); each emit returns one diffused pixel with its column,
// row and an end-of-frame flag, and the frame position wraps to a fresh load
// after the last pixel. Emits pushed before the frame is full, and loads pushed
// after, are accepted and dropped. The back end writes a load into the store as
// it leaves the command queue. An emit, once taken from the queue, gets two
// draws, each a 32-bit generator multiply then a remainder unit (eight
// restoring steps a cycle) over two dividend bytes in turn; then the address
// multiply and the single-port store read happen together, and the pixel
// moves into the output register once free. A two-beat command queue lets the
// front keep accepting while the back works, and the output register lets the
// back finish the next item while a result waits to be popped. The frame store
// needs no clearing pass after reset. Configuration writes are always ready
// and must be made only while the block is idle; a geometry write restarts the
// frame and a seed write reloads the generator at once.
module random_pixel_diffuse #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RANGE  = 200
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  rpd_pkg::in_item_t                 in_item,
  output logic                              empty,
  input  logic                              pop,
  output rpd_pkg::out_item_t                result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  // Largest geometry and range accepted: the parameter, limited to what the register fields can hold.
  localparam int WIDTH_CAP  = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
  localparam int HEIGHT_CAP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
  localparam int RANGE_CAP  = (MAX_RANGE > 255) ? 255 : MAX_RANGE;

  rpd_pkg::cfg_t      cfg;
  logic               cfg_we;
  logic               restart;
  logic               seed_load;
  logic [rpd_pkg::GEOM_W-1:0]  width_sat;
  logic [rpd_pkg::GEOM_W-1:0]  height_sat;
  logic [rpd_pkg::RANGE_W-1:0] range_sat;

  logic               q_push;
  logic               q_pop;
  rpd_pkg::cmd_t      q_cmd;
  rpd_pkg::cmd_t      q_head;
  rpd_pkg::q_status_t q_status;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign full      = q_status.full;

  // A geometry write restarts the raster position; a seed write reloads the
  // generator in the same cycle.
  assign restart   = cfg_we && (cfg_index == rpd_pkg::REG_FRAME_WIDTH
                             || cfg_index == rpd_pkg::REG_FRAME_HEIGHT);
  assign seed_load = cfg_we && (cfg_index == rpd_pkg::REG_RNG_SEED);

  // Written values are saturated into their legal ranges.
  always_comb begin
    width_sat = cfg_data[rpd_pkg::GEOM_W-1:0];
    if (width_sat == '0) begin
      width_sat = rpd_pkg::GEOM_W'(1);
    end else if (32'(width_sat) > 32'(WIDTH_CAP)) begin
      width_sat = rpd_pkg::GEOM_W'(WIDTH_CAP);
    end
    height_sat = cfg_data[rpd_pkg::GEOM_W-1:0];
    if (height_sat == '0) begin
      height_sat = rpd_pkg::GEOM_W'(1);
    end else if (32'(height_sat) > 32'(HEIGHT_CAP)) begin
      height_sat = rpd_pkg::GEOM_W'(HEIGHT_CAP);
    end
    range_sat = cfg_data[rpd_pkg::RANGE_W-1:0];
    if (32'(range_sat) > 32'(RANGE_CAP)) begin
      range_sat = rpd_pkg::RANGE_W'(RANGE_CAP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= rpd_pkg::GEOM_W'(WIDTH_CAP);
      cfg.frame_height <= rpd_pkg::GEOM_W'(HEIGHT_CAP);
      cfg.spread_range <= rpd_pkg::RESET_RANGE;
    end else if (cfg_we) begin
      case (cfg_index)
        rpd_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= width_sat;
        rpd_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= height_sat;
        rpd_pkg::REG_SPREAD_RANGE: cfg.spread_range <= range_sat;
        default: begin
        end
      endcase
    end
  end

  // The front decides which beats become commands and stamps each with its
  // raster position and end-of-frame flag.
  rpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_item  (in_item),
    .cfg      (cfg),
    .restart  (restart),
    .q_status (q_status),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  rpd_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .q_head   (q_head),
    .q_status (q_status)
  );

  // The back writes loads into the store and turns emits into results.
  rpd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .seed_load (seed_load),
    .seed      (cfg_data),
    .q_head    (q_head),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

@@ hw/rtl/rpd_front.sv @@
// Front end of the random pixel diffuse block: accepts items and classifies them.
// Tracks the raster position for loading and emitting; depends on rpd_pkg.
module rpd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rpd_pkg::in_item_t   in_item,
  input  rpd_pkg::cfg_t       cfg,
  input  logic                restart,
  input  rpd_pkg::q_status_t  q_status,
  output logic                q_push,
  output rpd_pkg::cmd_t       q_cmd
);

  logic                        loaded;
  logic [rpd_pkg::COORD_W-1:0] col;
  logic [rpd_pkg::COORD_W-1:0] row;
  logic                        accept;
  logic                        col_end;
  logic                        row_end;
  logic                        last;

  assign accept  = push && !q_status.full;
  assign col_end = ({1'b0, col} + 10'd1) >= {1'b0, cfg.frame_width};
  assign row_end = ({1'b0, row} + 10'd1) >= {1'b0, cfg.frame_height};
  assign last    = col_end && row_end;

  // A load counts only while the frame is filling, an emit only once it is full.
  assign q_push = accept && ((in_item.opcode == rpd_pkg::OP_EMIT) == loaded);

  always_comb begin
    q_cmd.is_emit = (in_item.opcode == rpd_pkg::OP_EMIT);
    q_cmd.pixel   = in_item.pixel_in;
    q_cmd.col     = col;
    q_cmd.row     = row;
    q_cmd.last    = last;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      loaded <= 1'b0;
      col    <= '0;
      row    <= '0;
    end else if (q_push) begin
      if (last) begin
        loaded <= !loaded;
        col    <= '0;
        row    <= '0;
      end else if (col_end) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/rpd_cmd_queue.sv @@
// Two-entry command queue between the front and the back.
// Holds rpd_pkg::cmd_t entries; depends on rpd_pkg.
module rpd_cmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_push,
  input  rpd_pkg::cmd_t      q_cmd,
  input  logic               q_pop,
  output rpd_pkg::cmd_t      q_head,
  output rpd_pkg::q_status_t q_status
);

  rpd_pkg::cmd_t              entries [rpd_pkg::QUEUE_DEPTH];
  logic [rpd_pkg::QPTR_W-1:0] wr_ptr;
  logic [rpd_pkg::QPTR_W-1:0] rd_ptr;
  logic [rpd_pkg::QPTR_W:0]   count;

  assign q_head         = entries[rd_ptr];
  assign q_status.full  = (count == (rpd_pkg::QPTR_W + 1)'(rpd_pkg::QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (q_push) begin
      entries[wr_ptr] <= q_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({q_push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/rpd_back.sv @@
// Back end of the random pixel diffuse block: frame store, generator, divider
// and output register. Depends on rpd_pkg and the assertion macro header.
`include "random_pixel_diffuse_macros.svh"
module rpd_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  rpd_pkg::cfg_t       cfg,
  input  logic                seed_load,
  input  logic [31:0]         seed,
  input  rpd_pkg::cmd_t       q_head,
  input  rpd_pkg::q_status_t  q_status,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output rpd_pkg::out_item_t  result
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Eight restoring steps of the remainder, one per dividend bit.
  function automatic logic [rpd_pkg::SPAN_W-1:0] mod_steps(
    input logic [rpd_pkg::SPAN_W-1:0] rem_in,
    input logic [7:0]                 bits_in,
    input logic [rpd_pkg::SPAN_W-1:0] span_in
  );
    logic [rpd_pkg::SPAN_W:0]   r;
    logic [rpd_pkg::SPAN_W-1:0] acc;
    acc = rem_in;
    for (int i = 7; i >= 0; i--) begin
      r = {acc, bits_in[i]};
      if (r >= {1'b0, span_in}) begin
        r = r - {1'b0, span_in};
      end
      acc = r[rpd_pkg::SPAN_W-1:0];
    end
    return acc;
  endfunction

  logic [31:0] store [DEPTH];

  rpd_pkg::back_state_t state;
  rpd_pkg::back_state_t state_next;

  rpd_pkg::cmd_t               cur;
  logic                        second;
  logic                        mod_phase;
  logic [rpd_pkg::SPAN_W-1:0]  rem;
  logic [rpd_pkg::SPAN_W-1:0]  dx;
  logic [rpd_pkg::SPAN_W-1:0]  dy;
  logic [31:0]                 gen_state;
  logic [31:0]                 rd_data;
  logic                        out_valid;
  rpd_pkg::out_item_t          out_reg;

  logic [rpd_pkg::SPAN_W-1:0]     span;
  logic [rpd_pkg::SPAN_W-1:0]     mod_result;
  logic signed [10:0]             sx;
  logic signed [10:0]             sy;
  logic                           in_frame;
  logic [rpd_pkg::COORD_W-1:0]    mul_row;
  logic [rpd_pkg::COORD_W-1:0]    mul_col;
  logic [2*rpd_pkg::COORD_W-1:0]  prod;
  logic [rpd_pkg::ADDR_SUM_W-1:0] addr_full;
  logic [AW-1:0]                  mem_addr;
  logic                           mem_we;
  logic                           mem_re;
  logic                           latch_cmd;
  logic                           slot_free;
  logic                           out_load;

  assign span       = {cfg.spread_range, 1'b1};
  assign mod_result = mod_steps(mod_phase ? rem : '0,
                                mod_phase ? gen_state[23:16] : {1'b0, gen_state[30:24]},
                                span);

  assign sx = $signed({2'b00, cur.col}) + $signed({2'b00, dx})
            - $signed({3'b000, cfg.spread_range});
  assign sy = $signed({2'b00, cur.row}) + $signed({2'b00, dy})
            - $signed({3'b000, cfg.spread_range});
  assign in_frame = !sx[10] && (sx[9:0] < {1'b0, cfg.frame_width})
                 && !sy[10] && (sy[9:0] < {1'b0, cfg.frame_height});

  assign prod      = mul_row * cfg.frame_width;
  assign addr_full = {1'b0, prod} + {{(rpd_pkg::COORD_W + 1){1'b0}}, mul_col};
  assign mem_addr  = AW'(addr_full);

  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;
  assign result    = out_reg;

  always_comb begin
    state_next = state;
    case (state)
      rpd_pkg::B_IDLE: begin
        if (!q_status.empty && q_head.is_emit) begin
          state_next = rpd_pkg::B_DRAW;
        end
      end
      rpd_pkg::B_DRAW: state_next = rpd_pkg::B_MOD;
      rpd_pkg::B_MOD: begin
        if (mod_phase) begin
          state_next = second ? rpd_pkg::B_ADDR : rpd_pkg::B_DRAW;
        end
      end
      rpd_pkg::B_ADDR: state_next = rpd_pkg::B_OUT;
      rpd_pkg::B_OUT: begin
        if (slot_free) begin
          state_next = rpd_pkg::B_IDLE;
        end
      end
      default: state_next = rpd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    latch_cmd = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    out_load  = 1'b0;
    mul_row   = q_head.row;
    mul_col   = q_head.col;
    case (state)
      rpd_pkg::B_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          latch_cmd = q_head.is_emit;
          mem_we    = !q_head.is_emit;
        end
      end
      rpd_pkg::B_ADDR: begin
        mem_re  = 1'b1;
        mul_row = in_frame ? sy[rpd_pkg::COORD_W-1:0] : cur.row;
        mul_col = in_frame ? sx[rpd_pkg::COORD_W-1:0] : cur.col;
      end
      rpd_pkg::B_OUT: out_load = slot_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= q_head.pixel;
    end
    if (mem_re) begin
      rd_data <= store[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rpd_pkg::B_IDLE;
      mod_phase <= 1'b0;
      second    <= 1'b0;
      out_valid <= 1'b0;
      gen_state <= rpd_pkg::RESET_SEED;
    end else begin
      state <= state_next;
      if (seed_load) begin
        gen_state <= seed;
      end else if (state == rpd_pkg::B_DRAW) begin
        gen_state <= gen_state * rpd_pkg::LCG_MUL + rpd_pkg::LCG_INC;
      end
      if (latch_cmd) begin
        second <= 1'b0;
      end else if (state == rpd_pkg::B_MOD && mod_phase) begin
        second <= 1'b1;
      end
      mod_phase <= (state == rpd_pkg::B_MOD) && !mod_phase;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (latch_cmd) begin
      cur <= q_head;
    end
    if (state == rpd_pkg::B_MOD) begin
      if (!mod_phase) begin
        rem <= mod_result;
      end else if (second) begin
        dy <= mod_result;
      end else begin
        dx <= mod_result;
      end
    end
    if (out_load) begin
      out_reg.pixel_out     <= rd_data;
      out_reg.out_x         <= cur.col[7:0];
      out_reg.out_y         <= cur.row[7:0];
      out_reg.last_of_frame <= cur.last;
    end
  end

  `RPD_ASSERT_NEXT(a_mod_two_halves, clk, rst, state == rpd_pkg::B_MOD && !mod_phase, state == rpd_pkg::B_MOD && mod_phase, "divider skipped its second half")
  `RPD_ASSERT_NEXT(a_result_held, clk, rst, state == rpd_pkg::B_OUT && out_valid && !pop, state == rpd_pkg::B_OUT, "waiting result would be overwritten")
  `RPD_ASSERT(a_result_source, clk, rst, $rose(out_valid) |-> $past(state) == rpd_pkg::B_OUT, "result appeared outside the output step")

endmodule
